@@ sv/drs_pkg.sv @@
`default_nettype none
package drs_pkg;

  localparam int PIX_W             = 16;
  localparam int CFG_DIM_W         = 13;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int OUT_CNT_W         = 25;
  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int QUEUE_DEPTH       = 2;

  // The mean never exceeds the largest pixel, so only PIX_W quotient bits are formed.
  localparam int MEAN_STEPS = PIX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MAX    = 3'd4;

  localparam logic [CFG_DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [CFG_DIM_W-1:0] ROI_SIZE_RST     = 13'd20;
  localparam logic [PIX_W-1:0]     DEPTH_MIN_RST    = 16'd0;
  localparam logic [PIX_W-1:0]     DEPTH_MAX_RST    = 16'hFFFF;

endpackage
`default_nettype wire

@@ sv/drs_front.sv @@
`default_nettype none
module drs_front import drs_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int POS_W = $clog2(MAX_DIMENSION),
  localparam int CNT_W = 2 * POS_W + 1,
  localparam int SUM_W = CNT_W + PIX_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  pix_accept,
  input  wire logic [PIX_W-1:0]      pix,
  output logic                       rec_push,
  output logic                       rec_center_valid,
  output logic [PIX_W-1:0]           rec_center_depth,
  output logic [CNT_W-1:0]           rec_count,
  output logic [SUM_W-1:0]           rec_sum,
  output logic [PIX_W-1:0]           rec_min,
  output logic [PIX_W-1:0]           rec_max
);

  localparam int CMP_W = ((POS_W + 1 > CFG_DIM_W) ? POS_W + 1 : CFG_DIM_W) + 2;
  localparam logic signed [CMP_W-1:0] ZERO = '0;
  localparam logic signed [CMP_W-1:0] ONE  = CMP_W'(1);
  localparam logic signed [CMP_W-1:0] LIM  = CMP_W'(MAX_DIMENSION);

  logic [CFG_DIM_W-1:0] width_r, height_r, roi_r;
  logic [PIX_W-1:0]     dmin_r, dmax_r;

  logic [POS_W-1:0] col_r, row_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PIX_W-1:0] min_r, min_nxt, max_r, max_nxt, ctr_r, ctr_nxt;
  logic             seen_r, seen_nxt;

  logic signed [CMP_W-1:0] w_raw, h_raw, w_s, h_s, cx, cy;
  logic signed [CMP_W-1:0] half_lo, half_hi, lo_raw, hi_raw, x0, x1, y0, y1;
  logic signed [CMP_W-1:0] col_s, row_s;
  logic in_win, depth_ok, take, is_ctr, row_end, frame_end;

  // Window bounds follow the live registers, so they are derived combinationally.
  assign w_raw = $signed(CMP_W'(width_r));
  assign h_raw = $signed(CMP_W'(height_r));
  assign w_s   = (w_raw == ZERO) ? ONE : ((w_raw > LIM) ? LIM : w_raw);
  assign h_s   = (h_raw == ZERO) ? ONE : ((h_raw > LIM) ? LIM : h_raw);
  assign cx    = w_s >>> 1;
  assign cy    = h_s >>> 1;

  assign half_lo = $signed(CMP_W'(roi_r >> 1));
  assign half_hi = $signed(CMP_W'(roi_r)) - half_lo;

  always_comb begin
    lo_raw = cx - half_lo;
    hi_raw = cx + half_hi;
    x0 = (lo_raw < ZERO) ? ZERO : lo_raw;
    x1 = (hi_raw > w_s) ? w_s : hi_raw;
  end

  always_comb begin
    logic signed [CMP_W-1:0] ylo, yhi;
    ylo = cy - half_lo;
    yhi = cy + half_hi;
    y0 = (ylo < ZERO) ? ZERO : ylo;
    y1 = (yhi > h_s) ? h_s : yhi;
  end

  assign col_s = $signed(CMP_W'(col_r));
  assign row_s = $signed(CMP_W'(row_r));

  assign in_win    = (col_s >= x0) && (col_s < x1) && (row_s >= y0) && (row_s < y1);
  assign depth_ok  = (pix != '0) && (pix >= dmin_r) && (pix <= dmax_r);
  assign take      = pix_accept && in_win && depth_ok;
  assign is_ctr    = (col_s == cx) && (row_s == cy);
  assign row_end   = (col_s + ONE) >= w_s;
  assign frame_end = row_end && ((row_s + ONE) >= h_s);

  always_comb begin
    sum_nxt  = take ? sum_r + SUM_W'(pix) : sum_r;
    cnt_nxt  = take ? cnt_r + CNT_W'(1) : cnt_r;
    min_nxt  = (take && (pix < min_r)) ? pix : min_r;
    max_nxt  = (take && (pix > max_r)) ? pix : max_r;
    ctr_nxt  = (pix_accept && is_ctr) ? pix : ctr_r;
    seen_nxt = (pix_accept && is_ctr) ? 1'b1 : seen_r;
  end

  // The frame record includes the last pixel of the frame.
  assign rec_push         = pix_accept && frame_end;
  assign rec_center_valid = seen_nxt && (ctr_nxt != '0);
  assign rec_center_depth = rec_center_valid ? ctr_nxt : '0;
  assign rec_count        = cnt_nxt;
  assign rec_sum          = sum_nxt;
  assign rec_min          = min_nxt;
  assign rec_max          = max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMAGE_WIDTH_RST;
      height_r <= IMAGE_HEIGHT_RST;
      roi_r    <= ROI_SIZE_RST;
      dmin_r   <= DEPTH_MIN_RST;
      dmax_r   <= DEPTH_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[CFG_DIM_W-1:0];
        CFG_ROI_SIZE:     roi_r    <= cfg_data[CFG_DIM_W-1:0];
        CFG_DEPTH_MIN:    dmin_r   <= cfg_data[PIX_W-1:0];
        CFG_DEPTH_MAX:    dmax_r   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      min_r  <= '1;
      max_r  <= '0;
      ctr_r  <= '0;
      seen_r <= 1'b0;
    end else if (pix_accept) begin
      if (frame_end) begin
        col_r  <= '0;
        row_r  <= '0;
        sum_r  <= '0;
        cnt_r  <= '0;
        min_r  <= '1;
        max_r  <= '0;
        ctr_r  <= '0;
        seen_r <= 1'b0;
      end else begin
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        min_r  <= min_nxt;
        max_r  <= max_nxt;
        ctr_r  <= ctr_nxt;
        seen_r <= seen_nxt;
        if (row_end) begin
          col_r <= '0;
          row_r <= row_r + POS_W'(1);
        end else begin
          col_r <= col_r + POS_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/drs_queue.sv @@
`default_nettype none
module drs_queue import drs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r;
  logic do_push, do_pop;

  assign full     = (level_r == LVL_W'(QUEUE_DEPTH));
  assign empty    = (level_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/drs_back.sv @@
`default_nettype none
module drs_back import drs_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
  localparam int POS_W = $clog2(MAX_DIMENSION),
  localparam int CNT_W = 2 * POS_W + 1,
  localparam int SUM_W = CNT_W + PIX_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rec_ready,
  input  wire logic             rec_center_valid,
  input  wire logic [PIX_W-1:0] rec_center_depth,
  input  wire logic [CNT_W-1:0] rec_count,
  input  wire logic [SUM_W-1:0] rec_sum,
  input  wire logic [PIX_W-1:0] rec_min,
  input  wire logic [PIX_W-1:0] rec_max,
  output logic                  rec_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_center_valid,
  output logic [PIX_W-1:0]      out_center_depth,
  output logic [OUT_CNT_W-1:0]  out_window_count,
  output logic                  out_window_valid,
  output logic [PIX_W-1:0]      out_window_mean,
  output logic [PIX_W-1:0]      out_window_min,
  output logic [PIX_W-1:0]      out_window_max
);

  localparam int STEP_W = $clog2(MEAN_STEPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        st_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r, rem_nxt, div_r;
  logic [PIX_W-1:0]  quo_r, quo_nxt;
  logic              cv_r;
  logic [PIX_W-1:0]  cd_r, min_r, max_r;

  logic [CNT_W:0] trial, diff;
  logic           ge, out_free, load_out, wv;

  // Restoring division: quo_r shifts the low sum bits out and the quotient bits in.
  assign trial   = {rem_r, quo_r[PIX_W-1]};
  assign diff    = trial - {1'b0, div_r};
  assign ge      = trial >= {1'b0, div_r};
  assign rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign quo_nxt = {quo_r[PIX_W-2:0], ge};

  assign out_free = !out_valid || !out_stall;
  assign load_out = (st_r == ST_DONE) && out_free;
  assign rec_pop  = (st_r == ST_IDLE) && rec_ready;
  assign wv       = (div_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (rec_ready) begin
            st_r <= (rec_count == '0) ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_r == '0) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      rem_r  <= rec_sum[SUM_W-1:PIX_W];
      quo_r  <= rec_sum[PIX_W-1:0];
      div_r  <= rec_count;
      step_r <= STEP_W'(MEAN_STEPS - 1);
      cv_r   <= rec_center_valid;
      cd_r   <= rec_center_depth;
      min_r  <= rec_min;
      max_r  <= rec_max;
    end else if (st_r == ST_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_center_valid <= cv_r;
      out_center_depth <= cd_r;
      out_window_count <= OUT_CNT_W'(div_r);
      out_window_valid <= wv;
      out_window_mean  <= wv ? quo_r : '0;
      out_window_min   <= wv ? min_r : '0;
      out_window_max   <= wv ? max_r : '0;
    end
  end

endmodule
`default_nettype wire

@@ sv/depth_roi_statistics_unit.sv @@
`default_nettype none
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_depth_pixel
// out_      output     out_valid/out_stall center, window count/valid/mean/min/max
// cfg_      input      cfg_we              cfg_index, cfg_data
//
// Pixels enter at one per cycle while in_stall is low; the front accumulates window statistics as they arrive.
// Each frame record then passes through the back: a load, the bit-serial mean divider and a
// move into the output register. An empty window skips the divider.
// The record queue holds two frames; it fills when frames end faster than the back finishes
// their records, as when short frames arrive or the output is stalled.
// Reset is synchronous and active low; it restores the register defaults and clears the frame.
// in_stall is high only while the record queue is full.
module depth_roi_statistics_unit import drs_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_depth_pixel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_center_valid,
  output logic [PIX_W-1:0]           out_center_depth,
  output logic [OUT_CNT_W-1:0]       out_window_count,
  output logic                       out_window_valid,
  output logic [PIX_W-1:0]           out_window_mean,
  output logic [PIX_W-1:0]           out_window_min,
  output logic [PIX_W-1:0]           out_window_max
);

  localparam int POS_W = $clog2(MAX_DIMENSION);
  localparam int CNT_W = 2 * POS_W + 1;
  localparam int SUM_W = CNT_W + PIX_W;
  localparam int REC_W = 1 + PIX_W + CNT_W + SUM_W + 2 * PIX_W;

  logic             f_push, f_cv;
  logic [PIX_W-1:0] f_cd, f_min, f_max;
  logic [CNT_W-1:0] f_cnt;
  logic [SUM_W-1:0] f_sum;

  logic             q_full, q_empty, q_pop;
  logic [REC_W-1:0] q_in, q_out;

  logic             b_cv;
  logic [PIX_W-1:0] b_cd, b_min, b_max;
  logic [CNT_W-1:0] b_cnt;
  logic [SUM_W-1:0] b_sum;

  assign in_stall = q_full;

  drs_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pix_accept       (in_valid && !q_full),
    .pix              (in_depth_pixel),
    .rec_push         (f_push),
    .rec_center_valid (f_cv),
    .rec_center_depth (f_cd),
    .rec_count        (f_cnt),
    .rec_sum          (f_sum),
    .rec_min          (f_min),
    .rec_max          (f_max)
  );

  assign q_in = {f_cv, f_cd, f_cnt, f_sum, f_min, f_max};

  drs_queue #(.WIDTH(REC_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {b_cv, b_cd, b_cnt, b_sum, b_min, b_max} = q_out;

  drs_back #(.MAX_DIMENSION(MAX_DIMENSION)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec_ready        (!q_empty),
    .rec_center_valid (b_cv),
    .rec_center_depth (b_cd),
    .rec_count        (b_cnt),
    .rec_sum          (b_sum),
    .rec_min          (b_min),
    .rec_max          (b_max),
    .rec_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_center_valid (out_center_valid),
    .out_center_depth (out_center_depth),
    .out_window_count (out_window_count),
    .out_window_valid (out_window_valid),
    .out_window_mean  (out_window_mean),
    .out_window_min   (out_window_min),
    .out_window_max   (out_window_max)
  );

  // An empty window reports zero statistics.
  a_empty_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_valid |->
      out_window_mean == '0 && out_window_min == '0 && out_window_max == '0)
    else $error("empty window reports nonzero statistics");

  // A floored mean of accepted pixels always lies between their minimum and maximum.
  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_valid |->
      out_window_min <= out_window_mean && out_window_mean <= out_window_max)
    else $error("window mean outside of min/max range");

  a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_center_valid |-> out_center_depth == '0)
    else $error("invalid center reports a depth");

endmodule
`default_nettype wire
